>>> src/box_blur_3x3_edge_normalized_macros.svh
`ifndef BOX_BLUR_3X3_EDGE_NORMALIZED_MACROS_SVH
`define BOX_BLUR_3X3_EDGE_NORMALIZED_MACROS_SVH

// same-cycle implication, clocked on clk, off during rst
`define BB3_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, clocked on clk, off during rst
`define BB3_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> src/bb3_pkg.sv
`default_nettype none
package bb3_pkg;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 4096;
  localparam int DEF_CHANNELS   = 3;

  localparam int PIX_W      = 8;
  localparam int FW_W       = 11;
  localparam int FH_W       = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;
  localparam int SUM_W      = 12;
  localparam int CNT_W      = 4;
  localparam int RECIP_SHIFT = 18;
  localparam int RECIP_W    = 19;
  localparam int PROD_W     = SUM_W + RECIP_W;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  localparam logic [FW_W-1:0] RESET_FRAME_WIDTH  = 11'd1024;
  localparam logic [FH_W-1:0] RESET_FRAME_HEIGHT = 13'd1024;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_TAP   = 5'b00010,
    ST_DRAIN = 5'b00100,
    ST_MUL   = 5'b01000,
    ST_LOAD  = 5'b10000
  } state_t;

  typedef struct packed {
    logic accept;
    logic tap;
    logic mul;
    logic load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic has_out;
    logic tap_last;
    logic out_free;
  } dp_status_t;

  // ceil(2^18 / n), exact truncating divide for sums up to 9 * 255
  function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] n);
    logic [RECIP_W-1:0] r;
    unique case (n)
      4'd1:    r = 19'd262144;
      4'd2:    r = 19'd131072;
      4'd3:    r = 19'd87382;
      4'd4:    r = 19'd65536;
      4'd5:    r = 19'd52429;
      4'd6:    r = 19'd43691;
      4'd7:    r = 19'd37450;
      4'd8:    r = 19'd32768;
      4'd9:    r = 19'd29128;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

>>> src/box_blur_3x3_edge_normalized.sv
// channel  direction  handshake              payload
// in       input      in_valid / in_ready    command, in_red, in_green, in_blue
// out      output     out_valid / out_ready  out_red, out_green, out_blue, last_of_frame
// cfg      input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// a request that yields no pixel leaves the block idle; one that yields a pixel runs the taps:
// the nine taps are read one per cycle from the single read port of the line store
// followed by accumulate, multiply and load cycles
// result register lets the next request in while a pixel waits; a full register stalls load
// rst is synchronous; the line store is not cleared, border masking keeps unwritten entries out
`default_nettype none
module box_blur_3x3_edge_normalized
  import bb3_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  parameter int CHANNELS   = DEF_CHANNELS
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic                  command,
  input  wire logic [PIX_W-1:0]      in_red,
  input  wire logic [PIX_W-1:0]      in_green,
  input  wire logic [PIX_W-1:0]      in_blue,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [PIX_W-1:0]           out_red,
  output logic [PIX_W-1:0]           out_green,
  output logic [PIX_W-1:0]           out_blue,
  output logic                       last_of_frame,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  ctrl_cmd_t  cmd;
  dp_status_t sts;

  assign cfg_ready = 1'b1;

  bb3_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  bb3_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .CHANNELS   (CHANNELS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .command       (command),
    .in_red        (in_red),
    .in_green      (in_green),
    .in_blue       (in_blue),
    .cfg_valid     (cfg_valid),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_red       (out_red),
    .out_green     (out_green),
    .out_blue      (out_blue),
    .last_of_frame (last_of_frame)
  );

endmodule
`default_nettype wire

>>> src/bb3_ctrl.sv
`default_nettype none
module bb3_ctrl
  import bb3_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire dp_status_t sts,
  output ctrl_cmd_t       cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid && sts.has_out) state_next = ST_TAP;
      end
      ST_TAP: begin
        if (sts.tap_last) state_next = ST_DRAIN;
      end
      ST_DRAIN: state_next = ST_MUL;
      ST_MUL:   state_next = ST_LOAD;
      ST_LOAD: begin
        if (sts.out_free) state_next = ST_IDLE;
      end
      default:  state_next = ST_IDLE;
    endcase
  end

  assign in_ready   = (state == ST_IDLE);
  assign cmd.accept = (state == ST_IDLE) && in_valid;
  assign cmd.tap    = (state == ST_TAP);
  assign cmd.mul    = (state == ST_MUL);
  assign cmd.load   = (state == ST_LOAD) && sts.out_free;

endmodule
`default_nettype wire

>>> src/bb3_dp.sv
`default_nettype none
module bb3_dp
  import bb3_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  parameter int CHANNELS   = DEF_CHANNELS
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire ctrl_cmd_t             cmd,
  output dp_status_t                 sts,
  input  wire logic                  command,
  input  wire logic [PIX_W-1:0]      in_red,
  input  wire logic [PIX_W-1:0]      in_green,
  input  wire logic [PIX_W-1:0]      in_blue,
  input  wire logic                  cfg_valid,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [PIX_W-1:0]           out_red,
  output logic [PIX_W-1:0]           out_green,
  output logic [PIX_W-1:0]           out_blue,
  output logic                       last_of_frame
);

  localparam int RING = 2 * MAX_WIDTH + 3;
  localparam int AW   = $clog2(RING);
  localparam int CW   = $clog2(MAX_WIDTH + 1);
  localparam int HW   = $clog2(MAX_HEIGHT + 1);
  localparam int RW   = $clog2(MAX_HEIGHT + 2);

  logic [FW_W-1:0] frame_width;
  logic [FH_W-1:0] frame_height;
  logic [CW-1:0]   eff_w;
  logic [HW-1:0]   eff_h;

  logic [CW-1:0] in_col;
  logic [RW-1:0] in_row;
  logic [CW-1:0] out_col;
  logic [HW-1:0] out_row;
  logic [AW-1:0] wptr;
  logic [AW-1:0] item_slot;

  logic [3*PIX_W-1:0] mem [RING];
  logic [3*PIX_W-1:0] rdata;
  logic [AW-1:0]      rd_addr;
  logic               rd_en;
  logic               rd_en_d;
  logic               wr_en;
  logic [3*PIX_W-1:0] wdata;

  logic [1:0]       tr;
  logic [1:0]       tc;
  logic [CNT_W-1:0] cnt;
  logic [SUM_W-1:0] sum_r, sum_g, sum_b;
  logic [PROD_W-1:0] prod_r, prod_g, prod_b;

  logic cfg_wr;
  logic in_row_live;
  logic in_col_end;
  logic out_col_end;
  logic out_row_end;
  logic last_now;
  logic row_ok;
  logic col_ok;
  logic [AW-1:0] w_a;
  logic [AW-1:0] base;
  logic [AW-1:0] off;

  assign cfg_wr = cfg_valid;

  always_comb begin
    if (frame_width == '0) begin
      eff_w = CW'(1);
    end else if (32'(frame_width) > 32'(MAX_WIDTH)) begin
      eff_w = CW'(MAX_WIDTH);
    end else begin
      eff_w = CW'(frame_width);
    end
    if (frame_height == '0) begin
      eff_h = HW'(1);
    end else if (32'(frame_height) > 32'(MAX_HEIGHT)) begin
      eff_h = HW'(MAX_HEIGHT);
    end else begin
      eff_h = HW'(frame_height);
    end
  end

  assign in_row_live = in_row < RW'(eff_h);
  assign in_col_end  = in_col == eff_w - CW'(1);
  assign out_col_end = out_col == eff_w - CW'(1);
  assign out_row_end = out_row == eff_h - HW'(1);
  assign last_now    = out_col_end && out_row_end;

  assign sts.has_out  = (in_row >= RW'(2)) || ((in_row == RW'(1)) && (in_col != '0));
  assign sts.tap_last = (tr == 2'd2) && (tc == 2'd2);
  assign sts.out_free = !out_valid || out_ready;

  // line store write
  assign wr_en = cmd.accept && in_row_live;
  assign wdata = (command == CMD_PIXEL) ? {in_blue, in_green, in_red} : '0;

  // tap address: offset back from the current item's slot
  always_comb begin
    w_a = AW'(eff_w);
    unique case (tr)
      2'd0:    base = {w_a[AW-2:0], 1'b0} + AW'(2);
      2'd1:    base = w_a + AW'(2);
      default: base = AW'(2);
    endcase
    off = base - AW'(tc);
    if (item_slot >= off) begin
      rd_addr = item_slot - off;
    end else begin
      rd_addr = AW'((AW+1)'(item_slot) + (AW+1)'(RING) - (AW+1)'(off));
    end
    row_ok = !((tr == 2'd0) && (out_row == '0)) && !((tr == 2'd2) && out_row_end);
    col_ok = !((tc == 2'd0) && (out_col == '0)) && !((tc == 2'd2) && out_col_end);
  end

  assign rd_en = cmd.tap && row_ok && col_ok;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wptr] <= wdata;
    end
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  // positions and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= RESET_FRAME_WIDTH;
      frame_height <= RESET_FRAME_HEIGHT;
      in_col       <= '0;
      in_row       <= '0;
      out_col      <= '0;
      out_row      <= '0;
      wptr         <= '0;
    end else if (cfg_wr) begin
      if (cfg_index == REG_FRAME_WIDTH) begin
        frame_width <= cfg_data[FW_W-1:0];
      end else if (cfg_index == REG_FRAME_HEIGHT) begin
        frame_height <= cfg_data[FH_W-1:0];
      end
      if ((cfg_index == REG_FRAME_WIDTH) || (cfg_index == REG_FRAME_HEIGHT)) begin
        in_col  <= '0;
        in_row  <= '0;
        out_col <= '0;
        out_row <= '0;
        wptr    <= '0;
      end
    end else if (cmd.accept) begin
      wptr <= (wptr == AW'(RING - 1)) ? '0 : wptr + AW'(1);
      if (in_col_end) begin
        in_col <= '0;
        in_row <= in_row + RW'(1);
      end else begin
        in_col <= in_col + CW'(1);
      end
    end else if (cmd.load) begin
      if (last_now) begin
        in_col  <= '0;
        in_row  <= '0;
        out_col <= '0;
        out_row <= '0;
        wptr    <= '0;
      end else if (out_col_end) begin
        out_col <= '0;
        out_row <= out_row + HW'(1);
      end else begin
        out_col <= out_col + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      item_slot <= wptr;
    end
  end

  // tap walk and accumulation
  always_ff @(posedge clk) begin
    if (rst) begin
      tr      <= '0;
      tc      <= '0;
      cnt     <= '0;
      rd_en_d <= 1'b0;
    end else begin
      rd_en_d <= rd_en;
      if (cmd.accept) begin
        tr  <= '0;
        tc  <= '0;
        cnt <= '0;
      end else if (cmd.tap) begin
        if (rd_en) cnt <= cnt + CNT_W'(1);
        if (tc == 2'd2) begin
          tc <= '0;
          if (tr != 2'd2) tr <= tr + 2'd1;
        end else begin
          tc <= tc + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      sum_r <= '0;
      sum_g <= '0;
      sum_b <= '0;
    end else if (rd_en_d) begin
      sum_r <= sum_r + SUM_W'(rdata[PIX_W-1:0]);
      sum_g <= sum_g + SUM_W'(rdata[2*PIX_W-1:PIX_W]);
      sum_b <= sum_b + SUM_W'(rdata[3*PIX_W-1:2*PIX_W]);
    end
    if (cmd.mul) begin
      prod_r <= PROD_W'(sum_r) * PROD_W'(recip(cnt));
      prod_g <= PROD_W'(sum_g) * PROD_W'(recip(cnt));
      prod_b <= PROD_W'(sum_b) * PROD_W'(recip(cnt));
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_red       <= prod_r[RECIP_SHIFT +: PIX_W];
      out_green     <= (CHANNELS > 1) ? prod_g[RECIP_SHIFT +: PIX_W] : '0;
      out_blue      <= (CHANNELS > 2) ? prod_b[RECIP_SHIFT +: PIX_W] : '0;
      last_of_frame <= last_now;
    end
  end

`include "box_blur_3x3_edge_normalized_macros.svh"

  `BB3_ASSERT_NOW(a_taps_found, cmd.mul, (cnt != '0) && (cnt <= CNT_W'(9)), "no valid tap")
  `BB3_ASSERT_NOW(a_rd_in_ring, rd_en, rd_addr < AW'(RING - 1) || rd_addr == AW'(RING - 1), "tap address out of ring")
  `BB3_ASSERT_NEXT(a_last_restart, cmd.load && last_now && !cfg_wr, (wptr == '0) && (in_row == '0) && (out_row == '0), "frame not restarted")

endmodule
`default_nettype wire
